// ===== sv/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and constants of the framed packet receiver
// Holds the channel payload structs, the result kind codes, the register
// indexes and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

    // Input item: one received byte and the end-of-buffer flag.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_in_buffer;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] frame_length;
    } out_item_t;

    // Configuration register values as seen by the parser.
    typedef struct packed {
        logic [7:0]  start_byte_one;
        logic [7:0]  start_byte_two;
        logic [15:0] length_limit;
    } cfg_t;

    // Result kind codes.
    localparam logic [2:0] KIND_COMMAND  = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
    localparam logic [2:0] KIND_GOOD     = 3'd2;
    localparam logic [2:0] KIND_MISMATCH = 3'd3;
    localparam logic [2:0] KIND_REJECTED = 3'd4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ONE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_TWO    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_LIMIT = 2'd2;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] LENGTH_LIMIT_RESET = 16'd256;

    // CRC-16 constants: polynomial 0x1021, MSB first.
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Folds one byte into the CRC, eight bit steps MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((crc & CRC_TOP) != 16'h0000) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fpr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fpr_cfg_regs: configuration registers
// Takes register writes from the configuration channel; writes to an index
// beyond the register list are accepted and ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_cfg_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [fpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [fpr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output fpr_pkg::cfg_t                           cfg
);

    fpr_pkg::cfg_t cfg_reg;

    // The register file never stalls a transfer.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write on each configuration transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte_one <= 8'h00;
            cfg_reg.start_byte_two <= 8'h00;
            cfg_reg.length_limit   <= fpr_pkg::LENGTH_LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                fpr_pkg::REG_START_ONE: begin
                    cfg_reg.start_byte_one <= cfg_data[7:0];
                end
                fpr_pkg::REG_START_TWO: begin
                    cfg_reg.start_byte_two <= cfg_data[7:0];
                end
                fpr_pkg::REG_LENGTH_LIMIT: begin
                    cfg_reg.length_limit <= cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/fpr_parser.sv =====
// ----------------------------------------------------------------------------
// fpr_parser: frame parser and CRC-16 accumulator
// Tracks the position within a frame, folds each covered byte into the
// running check and forms at most one result per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fpr_pkg::cfg_t     cfg,
    input  wire logic              in_accept,
    input  wire fpr_pkg::in_item_t in_item,
    output logic                   res_valid,
    output fpr_pkg::out_item_t     res_item
);

    typedef enum logic [7:0] {
        ST_HUNT_ONE = 8'b0000_0001,
        ST_HUNT_TWO = 8'b0000_0010,
        ST_LEN_HI   = 8'b0000_0100,
        ST_LEN_LO   = 8'b0000_1000,
        ST_COMMAND  = 8'b0001_0000,
        ST_PAYLOAD  = 8'b0010_0000,
        ST_CHECK_HI = 8'b0100_0000,
        ST_CHECK_LO = 8'b1000_0000
    } state_t;

    state_t      state_reg,   state_next;
    logic [15:0] length_reg,  length_next;
    logic [15:0] remain_reg,  remain_next;
    logic [7:0]  check_hi_reg, check_hi_next;
    logic [15:0] crc_reg,     crc_next;

    logic [7:0]  b;
    logic [15:0] crc_upd;

    assign b       = in_item.rx_byte;
    assign crc_upd = fpr_pkg::crc16_byte(crc_reg, b);

    // Next-state and result logic for one byte.
    always_comb begin
        state_next    = state_reg;
        length_next   = length_reg;
        remain_next   = remain_reg;
        check_hi_next = check_hi_reg;
        crc_next      = crc_reg;
        res_valid     = 1'b0;
        res_item      = '0;

        unique case (state_reg)
            ST_HUNT_ONE: begin
                if (b == cfg.start_byte_one) begin
                    crc_next   = fpr_pkg::crc16_byte(16'h0000, b);
                    state_next = ST_HUNT_TWO;
                end
            end
            ST_HUNT_TWO: begin
                // A mismatch goes back to hunting without a second look.
                if (b == cfg.start_byte_two) begin
                    crc_next   = crc_upd;
                    state_next = ST_LEN_HI;
                end else begin
                    state_next = ST_HUNT_ONE;
                end
            end
            ST_LEN_HI: begin
                length_next = {b, 8'h00};
                crc_next    = crc_upd;
                state_next  = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                length_next = {length_reg[15:8], b};
                crc_next    = crc_upd;
                if (length_next >= cfg.length_limit) begin
                    res_valid             = 1'b1;
                    res_item.kind         = fpr_pkg::KIND_REJECTED;
                    res_item.frame_length = length_next;
                    state_next            = ST_HUNT_ONE;
                end else begin
                    state_next = ST_COMMAND;
                end
            end
            ST_COMMAND: begin
                crc_next           = crc_upd;
                res_valid          = 1'b1;
                res_item.kind      = fpr_pkg::KIND_COMMAND;
                res_item.data_byte = b;
                remain_next        = length_reg;
                // An empty payload goes straight to the check bytes.
                if (length_reg == 16'h0000) begin
                    state_next = ST_CHECK_HI;
                end else begin
                    state_next = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                crc_next           = crc_upd;
                res_valid          = 1'b1;
                res_item.kind      = fpr_pkg::KIND_PAYLOAD;
                res_item.data_byte = b;
                remain_next        = remain_reg - 16'd1;
                if (remain_reg == 16'd1) begin
                    state_next = ST_CHECK_HI;
                end
            end
            ST_CHECK_HI: begin
                check_hi_next = b;
                state_next    = ST_CHECK_LO;
            end
            ST_CHECK_LO: begin
                res_valid             = 1'b1;
                res_item.frame_length = length_reg;
                if ({check_hi_reg, b} == crc_reg) begin
                    res_item.kind = fpr_pkg::KIND_GOOD;
                end else begin
                    res_item.kind = fpr_pkg::KIND_MISMATCH;
                end
                state_next = ST_HUNT_ONE;
            end
            default: begin
                state_next = ST_HUNT_ONE;
            end
        endcase

        // The end of a buffer always returns the parser to hunting.
        if (in_item.last_in_buffer) begin
            state_next = ST_HUNT_ONE;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT_ONE;
        end else if (in_accept) begin
            state_reg <= state_next;
        end
    end

    // Frame data registers, meaningful only once the frame has set them.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            length_reg   <= length_next;
            remain_reg   <= remain_next;
            check_hi_reg <= check_hi_next;
            crc_reg      <= crc_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fpr_out_stage.sv =====
// ----------------------------------------------------------------------------
// fpr_out_stage: result register
// Holds one result for the output channel and lets a new input transfer in
// whenever the held result leaves in the same cycle or none is held.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_out_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_accept,
    input  wire logic               res_valid,
    input  wire fpr_pkg::out_item_t res_item,
    output logic                    in_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fpr_pkg::out_item_t      m_data
);

    logic               valid_reg;
    fpr_pkg::out_item_t data_reg;

    assign in_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    // Valid flag: cleared by an output transfer, set by a new result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_accept && res_valid) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (in_accept && res_valid) begin
            data_reg <= res_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/framed_packet_receiver_crc16.sv =====
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16: length-prefixed frame receiver with CRC-16
// Top level joining configuration registers, parser and result register.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one received byte per transfer with a flag that
//   marks the last byte of a buffer. The receiver hunts for the two start
//   bytes, reads a big-endian 16-bit length, then reports the command byte
//   and each payload byte as results, and finally checks the big-endian
//   CRC-16 (poly 0x1021, init 0) and reports good or mismatch. A length at
//   or above length_limit is reported as rejected right after it arrives.
//   The cfg channel writes registers 0..2; other indexes are ignored, and
//   writes are meant to happen while no frame is in flight.
//   A result appears on the m_ channel in the cycle after the byte that
//   causes it is transferred. Bytes pass at one per cycle, set by the
//   byte-wide CRC update between the state registers, unless a held result stalls s_ready.
//   Reset clears the parser to hunting, empties the result register and
//   restores the register defaults. While a result waits on a low m_ready,
//   s_ready is low; bytes that cause no result still pass whenever the
//   result register is empty or is being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_packet_receiver_crc16 (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire fpr_pkg::in_item_t               s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output fpr_pkg::out_item_t                   m_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fpr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    fpr_pkg::cfg_t      cfg;
    fpr_pkg::out_item_t res_item;
    logic               res_valid;
    logic               in_accept;

    assign in_accept = s_valid && s_ready;

    // Configuration registers.
    fpr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Frame parser.
    fpr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_item   (s_data),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    // Result register.
    fpr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .res_valid (res_valid),
        .res_item  (res_item),
        .in_ready  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== sv/fpr_checker.sv =====
// ----------------------------------------------------------------------------
// fpr_checker: port-level assertions for the frame receiver
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire fpr_pkg::out_item_t m_data
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    // No input transfer while a result is stalled.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input ready while result stalled");

    // Byte results carry no length, frame results carry no byte.
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
        (((m_data.kind == fpr_pkg::KIND_COMMAND) ||
          (m_data.kind == fpr_pkg::KIND_PAYLOAD)) && (m_data.frame_length == 16'h0000)) ||
        (((m_data.kind == fpr_pkg::KIND_GOOD) ||
          (m_data.kind == fpr_pkg::KIND_MISMATCH) ||
          (m_data.kind == fpr_pkg::KIND_REJECTED)) && (m_data.data_byte == 8'h00)))
        else $error("result fields inconsistent with kind");

endmodule

bind framed_packet_receiver_crc16 fpr_checker u_fpr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== verif/framed_packet_receiver_crc16_tb.sv =====
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16_tb: self-checking bench for the frame receiver
// A short table of hand-picked bytes runs first under the reset register
// values, then random traffic under a series of register settings: mostly
// well-formed frames with random content and random lengths, plus corrupted
// checks, cut-off frames and stray bytes. A bench-side frame tracker predicts
// every result, and each result transfer is checked against the oldest
// prediction while both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module framed_packet_receiver_crc16_tb;

    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD = 200;
    localparam int NUM_PHASES = 9;
    localparam int PHASE_BYTES = 215;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [fpr_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    // One row of the directed table, with an optional hand-written result.
    typedef struct {
        logic [7:0]         rx_byte;
        logic               last;
        bit                 known;
        fpr_pkg::out_item_t res;
    } dir_row_t;

    typedef struct {
        bit                 known;
        fpr_pkg::out_item_t res;
    } dir_expect_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    fpr_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    fpr_pkg::out_item_t m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [fpr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [fpr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Bench copy of the registers and of the parser state.
    logic [7:0]  cfg_s1 = 8'h00;
    logic [7:0]  cfg_s2 = 8'h00;
    logic [15:0] cfg_limit = fpr_pkg::LENGTH_LIMIT_RESET;
    logic [16:0] frame_pos = '0;
    logic [15:0] len_reg = '0;
    logic [15:0] chk_rx = '0;
    logic [15:0] chk_run = '0;

    fpr_pkg::out_item_t pending_results[$];
    dir_expect_t        dir_expect_q[$];
    dir_row_t           dir_table[$];

    int errors = 0;
    int bytes_taken = 0;
    int results_checked = 0;
    int n_good = 0;
    int n_bad_check = 0;
    int n_rejected = 0;
    int n_data = 0;
    int settings_used = 0;
    int phase_items = 0;
    int idle_cycles = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int stall_left = 0;
    bit steady_flow = 1'b0;

    framed_packet_receiver_crc16 u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // CRC-16 over one byte, fed one bit at a time from the top.
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ fpr_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Payload length for a generated frame under the current limit.
    function automatic logic [15:0] pick_len();
        int r;
        int cap;
        r = $urandom_range(0, 99);
        if (cfg_limit == 16'h0000) begin
            return 16'($urandom_range(0, 65535));
        end
        if (r < 8) begin
            return 16'($urandom_range(int'(cfg_limit), 65535));
        end
        cap = (r < 20) ? 64 : 10;
        if (cap > int'(cfg_limit) - 1) begin
            cap = int'(cfg_limit) - 1;
        end
        return 16'($urandom_range(0, cap));
    endfunction

    // Frame tracker: advances the bench parser state by one received byte.
    task automatic track_rx_byte(input fpr_pkg::in_item_t it, output bit got,
                                 output fpr_pkg::out_item_t res);
        logic [7:0] b;
        int pos;
        int check_at;
        b = it.rx_byte;
        pos = int'(frame_pos);
        check_at = 5 + int'(len_reg);
        got = 1'b0;
        res = '0;
        if (pos == 0) begin
            if (b == cfg_s1) begin
                chk_run = crc16_fold(16'h0000, b);
                frame_pos = 17'd1;
            end
        end else if (pos == 1) begin
            if (b == cfg_s2) begin
                chk_run = crc16_fold(chk_run, b);
                frame_pos = 17'd2;
            end else begin
                frame_pos = 17'd0;
            end
        end else if (pos == 2) begin
            len_reg = {b, 8'h00};
            chk_run = crc16_fold(chk_run, b);
            frame_pos = 17'd3;
        end else if (pos == 3) begin
            len_reg = {len_reg[15:8], b};
            chk_run = crc16_fold(chk_run, b);
            if (len_reg >= cfg_limit) begin
                got = 1'b1;
                res = {fpr_pkg::KIND_REJECTED, 8'h00, len_reg};
                frame_pos = 17'd0;
            end else begin
                frame_pos = 17'd4;
            end
        end else if (pos == 4) begin
            chk_run = crc16_fold(chk_run, b);
            got = 1'b1;
            res = {fpr_pkg::KIND_COMMAND, b, 16'h0000};
            frame_pos = 17'd5;
        end else if (pos < check_at) begin
            chk_run = crc16_fold(chk_run, b);
            got = 1'b1;
            res = {fpr_pkg::KIND_PAYLOAD, b, 16'h0000};
            frame_pos = frame_pos + 17'd1;
        end else if (pos == check_at) begin
            chk_rx = {b, 8'h00};
            frame_pos = frame_pos + 17'd1;
        end else begin
            chk_rx = {chk_rx[15:8], b};
            got = 1'b1;
            res = {(chk_rx == chk_run) ? fpr_pkg::KIND_GOOD : fpr_pkg::KIND_MISMATCH,
                   8'h00, len_reg};
            frame_pos = 17'd0;
        end
        // The end-of-buffer flag always drops the parser back to hunting.
        if (it.last_in_buffer) begin
            frame_pos = 17'd0;
        end
    endtask

    // Monitor: checks result transfers, then predicts from input transfers.
    always @(posedge aclk) begin
        bit                 got;
        fpr_pkg::out_item_t res;
        fpr_pkg::out_item_t want;
        dir_expect_t        de;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, %s%0d %s%02h %s%04h",
                             $time, "actual kind=", m_data.kind, "data=", m_data.data_byte,
                             "len=", m_data.frame_length);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.kind !== want.kind || m_data.data_byte !== want.data_byte ||
                        m_data.frame_length !== want.frame_length) begin
                        errors++;
                        $display("%0t: result mismatch, expected kind=%0d data=%02h len=%04h,",
                                 $time, want.kind, want.data_byte, want.frame_length);
                        $display("%0t:   actual kind=%0d data=%02h len=%04h",
                                 $time, m_data.kind, m_data.data_byte, m_data.frame_length);
                    end
                    results_checked++;
                    case (want.kind)
                        fpr_pkg::KIND_GOOD:     n_good++;
                        fpr_pkg::KIND_MISMATCH: n_bad_check++;
                        fpr_pkg::KIND_REJECTED: n_rejected++;
                        default:                n_data++;
                    endcase
                end
            end
            if (s_valid && s_ready) begin
                track_rx_byte(s_data, got, res);
                bytes_taken++;
                // Directed rows may carry a hand-written result instead.
                if (dir_expect_q.size() > 0) begin
                    de = dir_expect_q.pop_front();
                    if (de.known) begin
                        got = 1'b1;
                        res = de.res;
                    end
                end
                if (got) begin
                    pending_results.push_back(res);
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            stall_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offers one byte after a random gap and holds it until the transfer.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= {b, last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes the three registers, and the unused index when asked, back to back.
    task automatic program_regs(input logic [15:0] v1, input logic [15:0] v2,
                                input logic [15:0] vlim, input bit with_spare);
        logic [fpr_pkg::CFG_INDEX_W-1:0] idx[4];
        logic [15:0]                     val[4];
        int                              n;
        idx[0] = fpr_pkg::REG_START_ONE;
        idx[1] = fpr_pkg::REG_START_TWO;
        idx[2] = fpr_pkg::REG_LENGTH_LIMIT;
        idx[3] = REG_SPARE;
        val[0] = v1;
        val[1] = v2;
        val[2] = vlim;
        val[3] = 16'($urandom_range(0, 65535));
        n = with_spare ? 4 : 3;
        for (int i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (idx[i])
                fpr_pkg::REG_START_ONE:    cfg_s1 = val[i][7:0];
                fpr_pkg::REG_START_TWO:    cfg_s2 = val[i][7:0];
                fpr_pkg::REG_LENGTH_LIMIT: cfg_limit = val[i];
                default:                   ;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Sends one frame under the current registers; cut_at > 0 stops it early
    // after that many bytes and flags the last one as end of buffer.
    task automatic send_frame(input logic [15:0] plen, input bit corrupt, input int cut_at);
        logic [7:0]  fbytes[$];
        logic [15:0] chk;
        logic        last;
        int          n;
        fbytes.push_back(cfg_s1);
        fbytes.push_back(cfg_s2);
        fbytes.push_back(plen[15:8]);
        fbytes.push_back(plen[7:0]);
        if (plen < cfg_limit) begin
            fbytes.push_back(rand_byte());
            repeat (plen) fbytes.push_back(rand_byte());
            chk = 16'h0000;
            foreach (fbytes[i]) chk = crc16_fold(chk, fbytes[i]);
            if (corrupt) begin
                chk = chk ^ (16'h0001 << $urandom_range(0, 15));
            end
            fbytes.push_back(chk[15:8]);
            fbytes.push_back(chk[7:0]);
        end
        n = (cut_at > 0 && cut_at < fbytes.size()) ? cut_at : fbytes.size();
        last = (cut_at > 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            send_byte(fbytes[i], (i == n - 1) ? last : 1'b0);
        end
        phase_items += n;
    endtask

    // Stray bytes, rich in start bytes so that broken headers show up.
    task automatic send_noise();
        int         n;
        logic [7:0] b;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 2))
                0:       b = cfg_s1;
                1:       b = cfg_s2;
                default: b = rand_byte();
            endcase
            send_byte(b, (i == n - 1) ? ($urandom_range(0, 7) != 0) : 1'b0);
        end
    endtask

    task automatic plain_row(input logic [7:0] b, input logic last);
        dir_table.push_back('{rx_byte: b, last: last, known: 1'b0, res: '0});
    endtask

    task automatic known_row(input logic [7:0] b, input logic last, input logic [2:0] kind,
                             input logic [7:0] data, input logic [15:0] len);
        dir_table.push_back('{rx_byte: b, last: last, known: 1'b1, res: {kind, data, len}});
    endtask

    initial begin
        logic [7:0]  good_frame[6];
        logic [15:0] good_chk;
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic [15:0] lim;
        int          budget;
        int          r;
        bit          hold_done;
        bit          pause_done;

        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table under the reset registers: both start bytes zero,
        // length limit 256.
        good_frame = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF};
        good_chk = 16'h0000;
        foreach (good_frame[i]) good_chk = crc16_fold(good_chk, good_frame[i]);

        // Second start byte wrong: back to hunting.
        plain_row(8'h00, 1'b0);
        plain_row(8'h07, 1'b0);
        // Empty payload with a wrong check value.
        plain_row(8'h00, 1'b0);
        plain_row(8'h00, 1'b0);
        plain_row(8'h00, 1'b0);
        plain_row(8'h00, 1'b0);
        known_row(8'h00, 1'b0, fpr_pkg::KIND_COMMAND, 8'h00, 16'h0000);
        plain_row(8'h00, 1'b0);
        known_row(8'h01, 1'b0, fpr_pkg::KIND_MISMATCH, 8'h00, 16'h0000);
        // Length equal to the limit is rejected.
        plain_row(8'h00, 1'b0);
        plain_row(8'h00, 1'b0);
        plain_row(8'h01, 1'b0);
        known_row(8'h00, 1'b0, fpr_pkg::KIND_REJECTED, 8'h00, 16'h0100);
        // One payload byte and a correct check.
        plain_row(8'h00, 1'b0);
        plain_row(8'h00, 1'b0);
        plain_row(8'h00, 1'b0);
        plain_row(8'h01, 1'b0);
        known_row(8'hFF, 1'b0, fpr_pkg::KIND_COMMAND, 8'hFF, 16'h0000);
        known_row(8'hFF, 1'b0, fpr_pkg::KIND_PAYLOAD, 8'hFF, 16'h0000);
        plain_row(good_chk[15:8], 1'b0);
        known_row(good_chk[7:0], 1'b0, fpr_pkg::KIND_GOOD, 8'h00, 16'h0001);
        // Largest length, rejected, on a byte that also ends the buffer.
        plain_row(8'h00, 1'b0);
        plain_row(8'h00, 1'b0);
        plain_row(8'hFF, 1'b0);
        known_row(8'hFF, 1'b1, fpr_pkg::KIND_REJECTED, 8'h00, 16'hFFFF);
        // Largest accepted length, cut off by the end-of-buffer flag.
        plain_row(8'h00, 1'b0);
        plain_row(8'h00, 1'b0);
        plain_row(8'h00, 1'b0);
        plain_row(8'hFF, 1'b1);

        foreach (dir_table[i]) begin
            dir_expect_q.push_back('{known: dir_table[i].known, res: dir_table[i].res});
            send_byte(dir_table[i].rx_byte, dir_table[i].last);
        end
        wait_idle();

        // Random phases, one register setting each.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin s1 = 8'hA5; s2 = 8'h5A; lim = 16'd16; end
                1: begin s1 = 8'hFF; s2 = 8'hFF; lim = 16'hFFFF; end
                2: begin s1 = 8'h00; s2 = 8'hFF; lim = 16'd1; end
                3: begin s1 = 8'h7E; s2 = 8'h7E; lim = 16'd0; end
                6: begin
                    s1 = rand_byte();
                    s2 = rand_byte();
                    lim = 16'($urandom_range(2, 40));
                end
                8: begin
                    s1 = rand_byte();
                    s2 = rand_byte();
                    lim = 16'($urandom_range(1, 65535));
                end
                default: begin
                    s1 = rand_byte();
                    s2 = rand_byte();
                    lim = 16'($urandom_range(1, 300));
                end
            endcase
            program_regs({rand_byte(), s1}, {rand_byte(), s2}, lim, ph == 0);
            steady_flow = (ph == 6);
            phase_items = 0;
            budget = (ph == 3) ? 80 : PHASE_BYTES;

            // Near the top of the length range: one accepted frame cut short
            // and one rejected.
            if (ph == 1) begin
                send_frame(16'hFFFE, 1'b0, 12);
                send_frame(16'hFFFF, 1'b0, 0);
            end

            while (phase_items < budget) begin
                // The receiver holds off for a long stretch while bytes keep coming.
                if (ph == 0 && !hold_done && phase_items >= 100) begin
                    hold_requests++;
                    hold_done = 1'b1;
                end
                // The sender pauses until all results are in.
                if (ph == 4 && !pause_done && phase_items >= 100) begin
                    wait_idle();
                    pause_done = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 72) begin
                    send_frame(pick_len(), $urandom_range(0, 5) == 0, 0);
                end else if (r < 86) begin
                    send_frame(pick_len(), 1'b0, $urandom_range(1, 6));
                end else begin
                    send_noise();
                end
            end

            // Leave the parser hunting before the registers change.
            send_byte(rand_byte(), 1'b1);
            wait_idle();
            steady_flow = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end
        $display("Summary: %0d bytes in, %0d results checked, %0d register settings",
                 bytes_taken, results_checked, settings_used);
        $display("Summary: frames good %0d, bad check %0d, length rejected %0d, data bytes %0d",
                 n_good, n_bad_check, n_rejected, n_data);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
